[hdl/gcd_lcm_subtractive_unit_defines.svh]
// Assertion macros shared by the GCD/LCM unit modules.
`ifndef GCD_LCM_SUBTRACTIVE_UNIT_DEFINES_SVH
`define GCD_LCM_SUBTRACTIVE_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Clocked property, checked outside reset.
`define GLS_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("gcd_lcm_subtractive_unit: assertion failed");
// Clocked property, checked during reset as well.
`define GLS_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("gcd_lcm_subtractive_unit: assertion failed");
`else
`define GLS_ASSERT(label, clk, rst, prop)
`define GLS_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

[hdl/gcdlcm_pkg.sv]
// Shared widths, result codes and controller/datapath interface types.
package gcdlcm_pkg;

  localparam int OPERAND_WIDTH = 16;
  localparam int PRODUCT_WIDTH = 2 * OPERAND_WIDTH;
  localparam int COUNT_WIDTH   = $clog2(OPERAND_WIDTH);
  localparam int STATUS_WIDTH  = 2;

  // Result codes carried in the status field.
  localparam logic [STATUS_WIDTH-1:0] RES_OK        = 2'd0;
  localparam logic [STATUS_WIDTH-1:0] RES_BOTH_ZERO = 2'd1;
  localparam logic [STATUS_WIDTH-1:0] RES_ONE_ZERO  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture a new input word
    logic sub_step;   // one subtraction of the smaller from the larger
    logic div_start;  // set up the quotient a / gcd
    logic div_step;   // one restoring division step
    logic out_load;   // write the result word into the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic zero_case;  // an incoming operand is zero
    logic equal;      // both working operands are equal
    logic div_last;   // the current division step is the last one
  } dp_flags_t;

endpackage

[hdl/gcdlcm_ctrl.sv]
// Controller state machine for the GCD/LCM unit.
`include "gcd_lcm_subtractive_unit_defines.svh"

module gcdlcm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  gcdlcm_pkg::dp_flags_t flags,
  output gcdlcm_pkg::dp_cmd_t   cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SUB  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid_next;
  logic       slot_free;

  // The output register can take a word when empty or being drained.
  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE);

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = flags.zero_case ? S_FIN : S_SUB;
        end
      end
      S_SUB: begin
        if (flags.equal) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          cmd.sub_step = 1'b1;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (flags.div_last) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Output word valid flag.
  always_comb begin
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_stall) begin
      out_valid_next = out_valid;
    end else begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  `GLS_ASSERT(a_out_load_free, clk, rst, cmd.out_load |-> (!out_valid || !out_stall))
  `GLS_ASSERT_ALWAYS(a_cmd_onehot, clk, $onehot0(cmd))
  `GLS_ASSERT(a_div_to_fin, clk, rst, (state == S_DIV && flags.div_last) |=> state == S_FIN)

endmodule

[hdl/gcdlcm_dp.sv]
// Datapath for the GCD/LCM unit: subtractor, divider, multiplier, output register.
`include "gcd_lcm_subtractive_unit_defines.svh"

module gcdlcm_dp (
  input  logic                                      clk,
  input  logic                                      rst,
  input  gcdlcm_pkg::dp_cmd_t                       cmd,
  output gcdlcm_pkg::dp_flags_t                     flags,
  input  logic [gcdlcm_pkg::OPERAND_WIDTH-1:0]      first_operand,
  input  logic [gcdlcm_pkg::OPERAND_WIDTH-1:0]      second_operand,
  output logic [gcdlcm_pkg::STATUS_WIDTH-1:0]       status,
  output logic [gcdlcm_pkg::OPERAND_WIDTH-1:0]      divisor,
  output logic [gcdlcm_pkg::PRODUCT_WIDTH-1:0]      multiple
);

  localparam int W = gcdlcm_pkg::OPERAND_WIDTH;
  localparam int P = gcdlcm_pkg::PRODUCT_WIDTH;
  localparam int C = gcdlcm_pkg::COUNT_WIDTH;

  logic [W-1:0]   x;
  logic [W-1:0]   y;
  logic [W-1:0]   a_keep;
  logic [W-1:0]   b_keep;
  logic [gcdlcm_pkg::STATUS_WIDTH-1:0] res_code;
  logic [W-1:0]   rem;
  logic [W-1:0]   quo;
  logic [C-1:0]   cnt;
  logic [W:0]     shifted;
  logic [W+1:0]   trial;
  logic           fits;
  logic [P-1:0]   product;
  logic [gcdlcm_pkg::STATUS_WIDTH-1:0] code_in;

  // Classify the incoming operands.
  always_comb begin
    if (first_operand == '0 && second_operand == '0) begin
      code_in = gcdlcm_pkg::RES_BOTH_ZERO;
    end else if (first_operand == '0 || second_operand == '0) begin
      code_in = gcdlcm_pkg::RES_ONE_ZERO;
    end else begin
      code_in = gcdlcm_pkg::RES_OK;
    end
  end

  assign flags.zero_case = (first_operand == '0) || (second_operand == '0);
  assign flags.equal     = (x == y);
  assign flags.div_last  = (cnt == C'(W - 1));

  // One restoring division step of a by the gcd held in x.
  assign shifted = {rem, quo[W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, x};
  assign fits    = !trial[W+1];

  // The quotient a / gcd times b is the lcm and fits in the product width.
  assign product = P'(quo) * P'(b_keep);

  // Working registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x        <= first_operand;
      y        <= second_operand;
      a_keep   <= first_operand;
      b_keep   <= second_operand;
      res_code <= code_in;
    end else if (cmd.sub_step) begin
      if (x > y) begin
        x <= x - y;
      end else begin
        y <= y - x;
      end
    end
    if (cmd.div_start) begin
      rem <= '0;
      quo <= a_keep;
      cnt <= '0;
    end else if (cmd.div_step) begin
      rem <= fits ? trial[W-1:0] : shifted[W-1:0];
      quo <= {quo[W-2:0], fits};
      cnt <= cnt + C'(1);
    end
  end

  // Output register; x | y is the gcd, the nonzero operand, or zero.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status   <= res_code;
      divisor  <= x | y;
      multiple <= (res_code == gcdlcm_pkg::RES_OK) ? product : '0;
    end
  end

  `GLS_ASSERT(a_sub_distinct, clk, rst, cmd.sub_step |-> (x != y && x != '0 && y != '0))
  `GLS_ASSERT(a_div_start_equal, clk, rst, cmd.div_start |-> x == y)
  `GLS_ASSERT(a_rem_below_gcd, clk, rst, cmd.div_step |=> rem < x)

endmodule

[hdl/gcd_lcm_subtractive_unit.sv]
// Top level of the subtractive GCD and LCM unit.
//
//   channel  direction  handshake           word
//   input    in         in_valid/in_stall   first_operand, second_operand
//   output   out        out_valid/out_stall status, divisor, multiple
//
// An item with a zero operand goes from acceptance straight to the result state.
// Otherwise it passes through S subtractions of the GCD loop (up to 2^OPERAND_WIDTH - 2)
// and then the divider, which adds one bit a cycle; the result state waits for a free output register.
// One item is in work at a time; in_stall is high from acceptance until its result is stored.
// A stalled result waits in the output register while the next item is accepted and worked on.
// Reset clears the controller and the output valid flag.
module gcd_lcm_subtractive_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [gcdlcm_pkg::OPERAND_WIDTH-1:0] first_operand,
  input  logic [gcdlcm_pkg::OPERAND_WIDTH-1:0] second_operand,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [gcdlcm_pkg::STATUS_WIDTH-1:0]  status,
  output logic [gcdlcm_pkg::OPERAND_WIDTH-1:0] divisor,
  output logic [gcdlcm_pkg::PRODUCT_WIDTH-1:0] multiple
);

  gcdlcm_pkg::dp_cmd_t   cmd;
  gcdlcm_pkg::dp_flags_t flags;

  // Sequencer.
  gcdlcm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .flags     (flags),
    .cmd       (cmd)
  );

  // Arithmetic and result register.
  gcdlcm_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .flags          (flags),
    .first_operand  (first_operand),
    .second_operand (second_operand),
    .status         (status),
    .divisor        (divisor),
    .multiple       (multiple)
  );

endmodule
